// File: hw/rtl/scdb_pkg.sv
package scdb_pkg;

    localparam int MAX_ENTRIES_DEF       = 8;
    localparam int MAX_SLOTS_DEF         = 32;
    localparam int SECTORS_PER_ENTRY     = 16;
    localparam int SECTORS_PER_ENTRY_LOG2 = 4;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

    localparam logic [16:0] COUNT_LIMIT_48 = 17'd65536;
    localparam logic [16:0] COUNT_LIMIT_28 = 17'd256;

    localparam logic [7:0] ATA_READ_DMA       = 8'hC8;
    localparam logic [7:0] ATA_READ_DMA_EXT   = 8'h25;
    localparam logic [7:0] ATA_WRITE_DMA      = 8'hCA;
    localparam logic [7:0] ATA_WRITE_DMA_EXT  = 8'h35;
    localparam logic [7:0] ATA_FLUSH_CACHE    = 8'hE7;
    localparam logic [7:0] ATA_FLUSH_CACHE_EXT = 8'hEA;
    localparam logic [7:0] DEVICE_LBA         = 8'h40;

    typedef enum logic [1:0] {
        OP_READ     = 2'd0,
        OP_WRITE    = 2'd1,
        OP_FLUSH    = 2'd2,
        OP_COMPLETE = 2'd3
    } opcode_t;

    typedef enum logic [2:0] {
        KIND_HEADER     = 3'd0,
        KIND_ENTRY      = 3'd1,
        KIND_REJECT     = 3'd2,
        KIND_NO_SLOT    = 3'd3,
        KIND_COMPLETION = 3'd4
    } kind_t;

    typedef enum logic [1:0] {
        REG_LBA48_MODE      = 2'd0,
        REG_BLOCK_SIZE_LOG2 = 2'd1,
        REG_SLOT_LIMIT      = 2'd2
    } cfg_reg_t;

    typedef enum logic {
        BK_IDLE,
        BK_ENTRY
    } back_state_t;

    // one classified command as it travels from front to back
    typedef struct packed {
        kind_t        kind;
        logic [4:0]   slot;
        logic         write_flag;
        logic [5:0]   entry_total;
        logic [7:0]   ata_command;
        logic [47:0]  lba_field;
        logic [15:0]  count_field;
        logic [7:0]   device_field;
        logic [63:0]  buffer_address;
        logic [16:0]  sector_total;
        logic [31:0]  done_slots;
    } desc_t;

    typedef struct packed {
        kind_t        kind;
        logic [4:0]   slot;
        logic         write_flag;
        logic [5:0]   entry_total;
        logic [7:0]   ata_command;
        logic [47:0]  lba_field;
        logic [15:0]  count_field;
        logic [7:0]   device_field;
        logic [63:0]  entry_address;
        logic [21:0]  entry_bytes_minus_one;
        logic [31:0]  done_slots;
        logic         last;
    } result_t;

    typedef struct packed {
        logic lba48_mode;
        logic [3:0] block_size_log2;
        logic [5:0] slot_limit;
    } cfg_t;

endpackage

// File: hw/rtl/sata_command_descriptor_builder.sv
// Builds AHCI command descriptors from block requests. Read, write and flush requests are
// range-checked, given the lowest free command slot (not active in hardware, not pending),
// and turned into one header result followed by one scatter entry per 16 sectors; a
// completion event reports and clears the pending slots the hardware no longer shows active.
// The front end classifies an item in the cycle it is accepted and places it in a two-entry
// descriptor queue; the back end sequencer emits one result per cycle unless out_stall holds it.
// A request with N scatter entries (at most MAX_ENTRIES) gives a header and N entries; rejects,
// no-slot results, flushes and completions give one result. Input is stalled only while the
// descriptor queue is full. Configuration writes are always ready and take effect at once.
module sata_command_descriptor_builder #(
    parameter int MAX_ENTRIES = scdb_pkg::MAX_ENTRIES_DEF,
    parameter int MAX_SLOTS   = scdb_pkg::MAX_SLOTS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [5:0]  cfg_data,

    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  opcode,
    input  logic [47:0] start_lba,
    input  logic [16:0] sector_total,
    input  logic [63:0] buffer_address,
    input  logic [31:0] hw_active_slots,

    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  kind,
    output logic [4:0]  slot,
    output logic        write_flag,
    output logic [5:0]  entry_total,
    output logic [7:0]  ata_command,
    output logic [47:0] lba_field,
    output logic [15:0] count_field,
    output logic [7:0]  device_field,
    output logic [63:0] entry_address,
    output logic [21:0] entry_bytes_minus_one,
    output logic [31:0] done_slots,
    output logic        last
);

    scdb_pkg::cfg_t       cfg_reg;
    scdb_pkg::desc_t      front_desc;
    scdb_pkg::desc_t      head;
    scdb_pkg::result_t    res;
    logic                 accept;
    logic                 q_full;
    logic                 q_not_empty;
    logic                 pop;

    assign cfg_ready = 1'b1;
    assign in_stall  = q_full;
    assign accept    = in_valid && !q_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.lba48_mode      <= 1'b0;
            cfg_reg.block_size_log2 <= 4'd9;
            cfg_reg.slot_limit      <= 6'd32;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                scdb_pkg::REG_LBA48_MODE:      cfg_reg.lba48_mode      <= cfg_data[0];
                scdb_pkg::REG_BLOCK_SIZE_LOG2: cfg_reg.block_size_log2 <= cfg_data[3:0];
                scdb_pkg::REG_SLOT_LIMIT:      cfg_reg.slot_limit      <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    scdb_front #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .MAX_SLOTS   (MAX_SLOTS)
    ) u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .lba48_mode      (cfg_reg.lba48_mode),
        .slot_limit      (cfg_reg.slot_limit),
        .accept          (accept),
        .opcode          (opcode),
        .start_lba       (start_lba),
        .sector_total    (sector_total),
        .buffer_address  (buffer_address),
        .hw_active_slots (hw_active_slots),
        .desc            (front_desc)
    );

    scdb_queue u_queue (
        .clk              (clk),
        .rst_n            (rst_n),
        .push             (accept),
        .push_data        (front_desc),
        .full             (q_full),
        .pop              (pop),
        .not_empty        (q_not_empty),
        .head             (head)
    );

    scdb_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .block_size_log2 (cfg_reg.block_size_log2),
        .head_valid      (q_not_empty),
        .head            (head),
        .pop             (pop),
        .out_stall       (out_stall),
        .out_valid       (out_valid),
        .res             (res)
    );

    assign kind                  = res.kind;
    assign slot                  = res.slot;
    assign write_flag            = res.write_flag;
    assign entry_total           = res.entry_total;
    assign ata_command           = res.ata_command;
    assign lba_field             = res.lba_field;
    assign count_field           = res.count_field;
    assign device_field          = res.device_field;
    assign entry_address         = res.entry_address;
    assign entry_bytes_minus_one = res.entry_bytes_minus_one;
    assign done_slots            = res.done_slots;
    assign last                  = res.last;

endmodule

// File: hw/rtl/scdb_front.sv
module scdb_front #(
    parameter int MAX_ENTRIES = scdb_pkg::MAX_ENTRIES_DEF,
    parameter int MAX_SLOTS   = scdb_pkg::MAX_SLOTS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               lba48_mode,
    input  logic [5:0]         slot_limit,
    input  logic               accept,
    input  logic [1:0]         opcode,
    input  logic [47:0]        start_lba,
    input  logic [16:0]        sector_total,
    input  logic [63:0]        buffer_address,
    input  logic [31:0]        hw_active_slots,
    output scdb_pkg::desc_t    desc
);

    logic [31:0] pending_reg;
    logic [31:0] pending_next;
    logic [5:0]  limit;
    logic [31:0] free_mask;
    logic        found;
    logic [4:0]  free_slot;
    logic [17:0] count_round;
    logic [13:0] entries;
    logic        over_limit;

    assign limit = (slot_limit > 6'(MAX_SLOTS)) ? 6'(MAX_SLOTS) : slot_limit;
    assign over_limit = lba48_mode ? (sector_total > scdb_pkg::COUNT_LIMIT_48)
                                   : (sector_total > scdb_pkg::COUNT_LIMIT_28);
    assign count_round = {1'b0, sector_total} + 18'(scdb_pkg::SECTORS_PER_ENTRY - 1);
    assign entries = 14'(count_round >> scdb_pkg::SECTORS_PER_ENTRY_LOG2);

    always_comb
    begin
        for (int i = 0; i < 32; i++)
        begin
            free_mask[i] = !(hw_active_slots[i] | pending_reg[i]) && (6'(i) < limit);
        end
    end

    assign found = |free_mask;

    // lowest free slot wins
    always_comb
    begin
        free_slot = '0;
        for (int i = 31; i >= 0; i--)
        begin
            if (free_mask[i])
            begin
                free_slot = 5'(i);
            end
        end
    end

    always_comb
    begin
        desc = '0;
        desc.kind = scdb_pkg::KIND_REJECT;
        if (scdb_pkg::opcode_t'(opcode) == scdb_pkg::OP_COMPLETE)
        begin
            desc.kind = scdb_pkg::KIND_COMPLETION;
            desc.done_slots = pending_reg & ~hw_active_slots;
        end
        else if (over_limit)
        begin
            desc.kind = scdb_pkg::KIND_REJECT;
        end
        else if (!found)
        begin
            desc.kind = scdb_pkg::KIND_NO_SLOT;
        end
        else if (scdb_pkg::opcode_t'(opcode) == scdb_pkg::OP_FLUSH)
        begin
            desc.kind = scdb_pkg::KIND_HEADER;
            desc.slot = free_slot;
            desc.ata_command = lba48_mode ? scdb_pkg::ATA_FLUSH_CACHE_EXT
                                          : scdb_pkg::ATA_FLUSH_CACHE;
            desc.device_field = scdb_pkg::DEVICE_LBA;
        end
        else if (sector_total == '0 || entries > 14'(MAX_ENTRIES))
        begin
            desc.kind = scdb_pkg::KIND_REJECT;
        end
        else
        begin
            desc.kind = scdb_pkg::KIND_HEADER;
            desc.slot = free_slot;
            desc.write_flag = (scdb_pkg::opcode_t'(opcode) == scdb_pkg::OP_WRITE);
            desc.entry_total = entries[5:0];
            desc.buffer_address = buffer_address;
            desc.sector_total = sector_total;
            if (scdb_pkg::opcode_t'(opcode) == scdb_pkg::OP_WRITE)
            begin
                desc.ata_command = lba48_mode ? scdb_pkg::ATA_WRITE_DMA_EXT
                                              : scdb_pkg::ATA_WRITE_DMA;
            end
            else
            begin
                desc.ata_command = lba48_mode ? scdb_pkg::ATA_READ_DMA_EXT
                                              : scdb_pkg::ATA_READ_DMA;
            end
            if (lba48_mode)
            begin
                desc.lba_field = start_lba;
                desc.count_field = sector_total[15:0];
                desc.device_field = scdb_pkg::DEVICE_LBA;
            end
            else
            begin
                desc.lba_field = {24'd0, start_lba[23:0]};
                desc.count_field = {8'd0, sector_total[7:0]};
                desc.device_field = scdb_pkg::DEVICE_LBA | {4'd0, start_lba[27:24]};
            end
        end
    end

    always_comb
    begin
        pending_next = pending_reg;
        if (accept)
        begin
            if (desc.kind == scdb_pkg::KIND_COMPLETION)
            begin
                pending_next = pending_reg & hw_active_slots;
            end
            else if (desc.kind == scdb_pkg::KIND_HEADER)
            begin
                pending_next = pending_reg | (32'd1 << desc.slot);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_next;
        end
    end

endmodule

// File: hw/rtl/scdb_queue.sv
module scdb_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  scdb_pkg::desc_t      push_data,
    output logic                 full,
    input  logic                 pop,
    output logic                 not_empty,
    output scdb_pkg::desc_t      head
);

    scdb_pkg::desc_t               mem_reg [scdb_pkg::QUEUE_DEPTH];
    logic [scdb_pkg::QPTR_W-1:0]   wr_ptr_reg;
    logic [scdb_pkg::QPTR_W-1:0]   rd_ptr_reg;
    logic [scdb_pkg::QCNT_W-1:0]   count_reg;
    logic [scdb_pkg::QCNT_W-1:0]   count_next;

    assign full      = (count_reg == scdb_pkg::QCNT_W'(scdb_pkg::QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !(pop && not_empty))
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push && pop && not_empty)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop && not_empty)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// File: hw/rtl/scdb_back.sv
module scdb_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [3:0]           block_size_log2,
    input  logic                 head_valid,
    input  scdb_pkg::desc_t      head,
    output logic                 pop,
    input  logic                 out_stall,
    output logic                 out_valid,
    output scdb_pkg::result_t    res
);

    scdb_pkg::back_state_t state_reg;
    scdb_pkg::back_state_t state_next;

    logic                 out_valid_reg;
    logic                 out_valid_next;
    scdb_pkg::result_t    res_reg;
    scdb_pkg::result_t    res_next;
    logic                 emit;
    logic                 out_free;

    logic [4:0]  slot_reg;
    logic        wr_reg;
    logic [5:0]  total_reg;
    logic [63:0] addr_reg;
    logic [16:0] left_reg;
    logic [5:0]  idx_reg;

    logic        is_last;
    logic [32:0] per_entry;
    logic [32:0] tail_bytes;
    logic [21:0] bytes_m1;

    assign out_free   = !out_valid_reg || !out_stall;
    assign is_last    = ({1'b0, idx_reg} + 7'd1) == {1'b0, total_reg};
    assign per_entry  = 33'(scdb_pkg::SECTORS_PER_ENTRY) << block_size_log2;
    assign tail_bytes = {16'd0, left_reg} << block_size_log2;
    assign bytes_m1   = 22'((is_last ? tail_bytes : per_entry) - 33'd1);

    always_comb
    begin
        state_next = state_reg;
        pop        = 1'b0;
        emit       = 1'b0;
        res_next   = '0;
        unique case (state_reg)
            scdb_pkg::BK_IDLE:
            begin
                if (out_free && head_valid)
                begin
                    pop  = 1'b1;
                    emit = 1'b1;
                    res_next.kind         = head.kind;
                    res_next.slot         = head.slot;
                    res_next.write_flag   = head.write_flag;
                    res_next.entry_total  = head.entry_total;
                    res_next.ata_command  = head.ata_command;
                    res_next.lba_field    = head.lba_field;
                    res_next.count_field  = head.count_field;
                    res_next.device_field = head.device_field;
                    res_next.done_slots   = head.done_slots;
                    res_next.last = (head.kind != scdb_pkg::KIND_HEADER) ||
                                    (head.entry_total == '0);
                    if (head.kind == scdb_pkg::KIND_HEADER && head.entry_total != '0)
                    begin
                        state_next = scdb_pkg::BK_ENTRY;
                    end
                end
            end
            scdb_pkg::BK_ENTRY:
            begin
                if (out_free)
                begin
                    emit = 1'b1;
                    res_next.kind          = scdb_pkg::KIND_ENTRY;
                    res_next.slot          = slot_reg;
                    res_next.write_flag    = wr_reg;
                    res_next.entry_total   = total_reg;
                    res_next.entry_address = addr_reg;
                    res_next.entry_bytes_minus_one = bytes_m1;
                    res_next.last          = is_last;
                    if (is_last)
                    begin
                        state_next = scdb_pkg::BK_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = scdb_pkg::BK_IDLE;
            end
        endcase
    end

    assign out_valid_next = out_free ? emit : out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= scdb_pkg::BK_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            res_reg <= res_next;
        end
        if (pop)
        begin
            slot_reg  <= head.slot;
            wr_reg    <= head.write_flag;
            total_reg <= head.entry_total;
            addr_reg  <= head.buffer_address;
            left_reg  <= head.sector_total;
            idx_reg   <= '0;
        end
        else if (state_reg == scdb_pkg::BK_ENTRY && emit)
        begin
            addr_reg <= addr_reg + {31'd0, per_entry};
            left_reg <= left_reg - 17'(scdb_pkg::SECTORS_PER_ENTRY);
            idx_reg  <= idx_reg + 6'd1;
        end
    end

    assign out_valid = out_valid_reg;
    assign res       = res_reg;

endmodule

// File: hw/rtl/scdb_checker.sv
module scdb_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_stall,
    input logic [2:0]  kind,
    input logic [4:0]  slot,
    input logic [5:0]  entry_total,
    input logic [7:0]  ata_command,
    input logic [63:0] entry_address,
    input logic        last
);

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(kind) && $stable(slot) &&
        $stable(entry_address) && $stable(last))
        else $error("stalled result changed");

    // a non-final transfer is followed at once by a scatter entry of the same slot
    a_entry_follows: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !last |=>
        out_valid && kind == scdb_pkg::KIND_ENTRY && slot == $past(slot))
        else $error("scatter entry missing after non-final result");

    // single-result kinds always close their item
    a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (kind == scdb_pkg::KIND_REJECT || kind == scdb_pkg::KIND_NO_SLOT ||
        kind == scdb_pkg::KIND_COMPLETION) |-> last)
        else $error("single result without last");

    // a header that announces entries is a read or write, never a flush
    a_header_entries: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == scdb_pkg::KIND_HEADER && !last |->
        entry_total != '0 && ata_command != scdb_pkg::ATA_FLUSH_CACHE &&
        ata_command != scdb_pkg::ATA_FLUSH_CACHE_EXT)
        else $error("header with entries has bad command");

endmodule

bind sata_command_descriptor_builder scdb_checker u_scdb_checker (.*);
